FILE: src/tspf_pkg.sv
// package for the transport stream sync and pid filter
// payload structs, command and register codes, header constants; no dependencies
package tspf_pkg;

    localparam int PACKET_LEN_DEF = 188;
    localparam int BYTE_W         = 8;
    localparam int PID_W          = 13;
    localparam int OFF_W          = 9;
    localparam int HDR_LEN        = 4;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h47;

    // command codes
    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // configuration register indexes
    localparam logic CFG_PID_A = 1'b0;
    localparam logic CFG_PID_B = 1'b1;

    localparam logic [PID_W-1:0] PID_A_RESET = 13'd0;
    localparam logic [PID_W-1:0] PID_B_RESET = 13'd16;

    typedef struct packed {
        logic              cmd;
        logic [BYTE_W-1:0] stream_byte;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [PID_W-1:0]  packet_pid;
        logic              unit_start;
        logic              first_of_packet;
        logic              last_of_packet;
    } t_out_item;

    // one delay line entry
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

FILE: src/tspf_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module tspf_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 188,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/ts_packet_sync_and_pid_filter.sv
// top level of the transport stream packet sync and pid payload filter
// uses tspf_pkg and two tspf_ram instances for the two-packet delay line
// a result passes the compute stage register and then the result register after the input request that
// pushes its byte out of the delay line is accepted; that byte arrived two packet lengths earlier
// throughput: one input request per cycle, held only by a stalled result register
// the delay line is two packet-long rams, read at accept so the read data lines up with the compute stage
// reset: synchronous active low; clears lock, header state, ring pointer and fill count,
// and restores the filters to their defaults;
// the rams are not cleared, a fill count masks entries that were never written
module ts_packet_sync_and_pid_filter import tspf_pkg::*; #(
    parameter int PACKET_LEN = PACKET_LEN_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input requests
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    // result requests
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item,
    // configuration writes
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [PID_W-1:0] i_cfg_data
);

    localparam int LINE_DEPTH = 2 * PACKET_LEN;
    localparam int PTR_W      = $clog2(PACKET_LEN);
    localparam int FILL_W     = $clog2(LINE_DEPTH + 1);

    // header byte positions inside a packet
    localparam logic [PTR_W-1:0] POS_PID_HI = PTR_W'(1);
    localparam logic [PTR_W-1:0] POS_PID_LO = PTR_W'(2);
    localparam logic [PTR_W-1:0] POS_CTRL   = PTR_W'(3);
    localparam logic [PTR_W-1:0] POS_ADAPT  = PTR_W'(HDR_LEN);
    localparam logic [PTR_W-1:0] POS_LAST   = PTR_W'(PACKET_LEN - 1);

    // filter registers
    logic [PID_W-1:0]  r_pid_a;
    logic [PID_W-1:0]  r_pid_b;

    // ring pointer and fill count of the delay line
    logic [PTR_W-1:0]  r_ptr;
    logic [FILL_W-1:0] r_fill;

    // compute stage: input register plus the two ram read registers
    logic              r_s1_valid;
    t_in_item          r_s1_item;
    logic [PTR_W-1:0]  r_s1_ptr;
    logic              r_s1_mid_ok;
    logic              r_s1_old_ok;

    // packet state
    logic              r_locked;
    logic [PTR_W-1:0]  r_pos;
    logic [PID_W-1:0]  r_pid;
    logic              r_us;
    logic [1:0]        r_ac;
    logic [OFF_W-1:0]  r_off;

    // result register
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic              n_locked;
    logic [PTR_W-1:0]  n_pos;
    logic [PID_W-1:0]  n_pid;
    logic              n_us;
    logic [1:0]        n_ac;
    logic [OFF_W-1:0]  n_off;

    logic              in_acc;
    logic              s1_go;
    logic              s1_fire;
    logic              emit;
    t_out_item         emit_item;
    t_entry            inc_entry;
    t_entry            mid_entry;
    t_entry            old_entry;
    logic [ENTRY_W-1:0] mid_raw;
    logic [ENTRY_W-1:0] old_raw;

    // the compute stage moves on whenever the result register can take its outcome
    assign s1_go      = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && s1_go;
    assign o_in_ready = !r_s1_valid || s1_go;
    assign in_acc     = i_in_valid && o_in_ready;

    assign inc_entry = (r_s1_item.cmd == CMD_DRAIN) ? '0 : {1'b1, r_s1_item.stream_byte};
    assign mid_entry = t_entry'(mid_raw);
    assign old_entry = t_entry'(old_raw);

    // the mid ram holds the last packet length of entries, the old ram the packet before it;
    // the read happens at accept so data lines up with the compute stage
    tspf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PACKET_LEN)
    ) u_ram_mid (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_ptr),
        .i_wdata (inc_entry),
        .i_re    (in_acc),
        .i_raddr (r_ptr),
        .o_rdata (mid_raw)
    );

    tspf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PACKET_LEN)
    ) u_ram_old (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_ptr),
        .i_wdata (mid_raw),
        .i_re    (in_acc),
        .i_raddr (r_ptr),
        .o_rdata (old_raw)
    );

    // sync search, header capture and filtering for the entry leaving the line
    always_comb begin
        logic              old_v;
        logic              mid_v;
        logic              lock_now;
        logic [PTR_W-1:0]  pos;
        logic [BYTE_W-1:0] b;

        n_locked  = r_locked;
        n_pos     = r_pos;
        n_pid     = r_pid;
        n_us      = r_us;
        n_ac      = r_ac;
        n_off     = r_off;
        emit      = 1'b0;
        emit_item = '0;

        // entries never written read as invalid
        old_v = r_s1_old_ok && old_entry.valid;
        mid_v = r_s1_mid_ok && mid_entry.valid;
        b     = old_entry.data;

        lock_now = !r_locked && old_v && (old_entry.data == SYNC_BYTE) &&
                   mid_v && (mid_entry.data == SYNC_BYTE) &&
                   inc_entry.valid && (inc_entry.data == SYNC_BYTE);

        pos = r_pos;
        if (lock_now) begin
            n_locked = 1'b1;
            pos      = '0;
            n_pos    = '0;
        end

        if (n_locked && old_v) begin
            if (pos == POS_PID_HI) begin
                n_us  = b[6];
                n_pid = {b[4:0], r_pid[BYTE_W-1:0]};
            end else if (pos == POS_PID_LO) begin
                n_pid = {r_pid[PID_W-1:BYTE_W], b};
            end else if (pos == POS_CTRL) begin
                n_ac  = b[5:4];
                n_off = OFF_W'(HDR_LEN) + OFF_W'(r_us);
            end else if (pos == POS_ADAPT) begin
                // control 2 or 3 carries an adaptation field
                if (r_ac[1]) begin
                    n_off = OFF_W'(HDR_LEN + 1) + OFF_W'(b) + OFF_W'(r_us);
                end
            end

            // filters are read here, at the moment of emission
            if ((pos >= POS_ADAPT) && (n_off < OFF_W'(PACKET_LEN)) &&
                (OFF_W'(pos) >= n_off) && ((n_pid == r_pid_a) || (n_pid == r_pid_b))) begin
                emit                      = 1'b1;
                emit_item.payload_byte    = b;
                emit_item.packet_pid      = n_pid;
                emit_item.unit_start      = n_us;
                emit_item.first_of_packet = (OFF_W'(pos) == n_off);
                emit_item.last_of_packet  = (pos == POS_LAST);
            end

            n_pos = (pos == POS_LAST) ? '0 : pos + PTR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pid_a     <= PID_A_RESET;
            r_pid_b     <= PID_B_RESET;
            r_ptr       <= '0;
            r_fill      <= '0;
            r_s1_valid  <= 1'b0;
            r_locked    <= 1'b0;
            r_pos       <= '0;
            r_pid       <= '0;
            r_us        <= 1'b0;
            r_ac        <= '0;
            r_off       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PID_A: r_pid_a <= i_cfg_data;
                    CFG_PID_B: r_pid_b <= i_cfg_data;
                    default: ;
                endcase
            end

            // accept into the compute stage, note which ram entries are filled
            if (in_acc) begin
                r_ptr  <= (r_ptr == POS_LAST) ? '0 : r_ptr + PTR_W'(1);
                if (r_fill != FILL_W'(LINE_DEPTH)) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end
            if (o_in_ready) begin
                r_s1_valid <= in_acc;
            end

            if (s1_fire) begin
                r_locked <= n_locked;
                r_pos    <= n_pos;
                r_pid    <= n_pid;
                r_us     <= n_us;
                r_ac     <= n_ac;
                r_off    <= n_off;
            end

            if (s1_go) begin
                r_out_valid <= s1_fire && emit;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item   <= i_in_item;
            r_s1_ptr    <= r_ptr;
            r_s1_mid_ok <= (r_fill >= FILL_W'(PACKET_LEN));
            r_s1_old_ok <= (r_fill == FILL_W'(LINE_DEPTH));
        end
        if (s1_fire && emit) begin
            r_out_item <= emit_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: bench/tb_ts_packet_sync_and_pid_filter.sv
// self-checking bench for ts_packet_sync_and_pid_filter
// needs tspf_pkg and the block's rtl; predicts payload requests from its own model of the block
`timescale 1ns / 1ps

module tb_ts_packet_sync_and_pid_filter;
    import tspf_pkg::*;

    localparam int PL             = PACKET_LEN_DEF;
    localparam int LINE_DEPTH     = 2 * PL;
    localparam int N_PHASES       = 7;     // six packets, then a flush of the delay line
    localparam int SETTLE_CYCLES  = 8;     // covers the compute stage and result register, plus margin
    localparam int WATCHDOG_LIMIT = 4000;

    // adaptation field control codes
    localparam logic [1:0] ADAPT_RESERVED    = 2'd0;
    localparam logic [1:0] PAYLOAD_ONLY      = 2'd1;
    localparam logic [1:0] ADAPT_ONLY        = 2'd2;
    localparam logic [1:0] ADAPT_AND_PAYLOAD = 2'd3;

    logic             i_clk;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             o_in_ready;
    t_in_item         in_item   = '0;
    logic             o_out_valid;
    logic             out_ready = 1'b0;
    t_out_item        out_item;
    logic             cfg_we    = 1'b0;
    logic             cfg_index = CFG_PID_A;
    logic [PID_W-1:0] cfg_data  = '0;

    // stimulus waiting for the driver, and payload requests still owed by the block
    t_in_item  pending_q [$];
    t_out_item expected_payload_q [$];
    int        err_cnt = 0;

    // handshake pacing
    int tx_wait    = 0;
    int rx_hold    = 0;
    bit tx_burst   = 1'b0;
    bit rx_burst   = 1'b0;
    int idle_count = 0;

    // predictor state: delay line as a ring, oldest entry at line_head
    t_entry             line_mem [LINE_DEPTH] = '{default: '0};
    int                 line_head      = 0;
    bit                 sync_locked    = 1'b0;
    int                 pkt_pos        = 0;
    logic [PID_W-1:0]   hdr_pid        = '0;
    logic               hdr_unit_start = 1'b0;
    logic [1:0]         hdr_ctrl       = ADAPT_RESERVED;
    logic [OFF_W-1:0]   pay_off        = '0;
    logic [PID_W-1:0]   flt_a          = PID_A_RESET;
    logic [PID_W-1:0]   flt_b          = PID_B_RESET;

    ts_packet_sync_and_pid_filter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit is_sync(t_entry e);
        return e.valid && e.data == SYNC_BYTE;
    endfunction

    // random idle gap before the next request, drawn only outside a burst stretch
    function automatic int draw_gap(bit burst);
        return burst ? 0 : int'($urandom_range(0, 15));
    endfunction

    // one accepted input request through the sync search, header parse and pid filter
    function automatic void sync_filter_predict(t_in_item it);
        t_entry            arriving;
        t_entry            departing;
        logic [BYTE_W-1:0] b;
        t_out_item         r;
        arriving.valid = (it.cmd == CMD_BYTE);
        arriving.data  = arriving.valid ? it.stream_byte : '0;
        departing      = line_mem[line_head];
        // lock needs three valid sync bytes a packet apart: leaving, middle, arriving
        if (!sync_locked && is_sync(departing) && is_sync(arriving) &&
            is_sync(line_mem[(line_head + PL) % LINE_DEPTH])) begin
            sync_locked = 1'b1;
            pkt_pos     = 0;
        end
        line_mem[line_head] = arriving;
        line_head           = (line_head + 1) % LINE_DEPTH;
        // drain fillers leave without emitting and without moving the packet position
        if (sync_locked && departing.valid) begin
            b = departing.data;
            case (pkt_pos)
                1: begin
                    hdr_unit_start = b[6];
                    hdr_pid        = {b[4:0], 8'h00};
                end
                2: hdr_pid[7:0] = b;
                3: begin
                    hdr_ctrl = b[5:4];
                    pay_off  = OFF_W'(HDR_LEN) + OFF_W'(hdr_unit_start);
                end
                4: begin
                    // reserved control behaves as payload only
                    if (hdr_ctrl == ADAPT_ONLY || hdr_ctrl == ADAPT_AND_PAYLOAD)
                        pay_off = OFF_W'(HDR_LEN) + OFF_W'(1) + OFF_W'(b)
                                  + OFF_W'(hdr_unit_start);
                end
                default: ;
            endcase
            // an offset of a packet length or more emits nothing
            if (pkt_pos >= HDR_LEN && pay_off < PL && pkt_pos >= pay_off &&
                (hdr_pid == flt_a || hdr_pid == flt_b)) begin
                r.payload_byte    = b;
                r.packet_pid      = hdr_pid;
                r.unit_start      = hdr_unit_start;
                r.first_of_packet = (pkt_pos == pay_off);
                r.last_of_packet  = (pkt_pos == PL - 1);
                expected_payload_q.push_back(r);
            end
            pkt_pos = (pkt_pos == PL - 1) ? 0 : pkt_pos + 1;
        end
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    // request driver: one item per accepted request, gap drawn per item
    always @(posedge i_clk) begin : request_driver
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_wait  <= 0;
        end else begin
            if (in_valid && o_in_ready)
                sync_filter_predict(in_item);
            if (!in_valid || o_in_ready) begin
                if (tx_wait > 0) begin
                    in_valid <= 1'b0;
                    tx_wait  <= tx_wait - 1;
                end else if (pending_q.size() != 0) begin
                    in_item  <= pending_q.pop_front();
                    in_valid <= 1'b1;
                    tx_wait  <= draw_gap(tx_burst);
                    if ($urandom_range(0, 49) == 0)
                        tx_burst <= !tx_burst;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compares each payload request with the oldest prediction
    always @(posedge i_clk) begin : result_monitor
        t_out_item want;
        int        hold;
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_hold   <= 0;
        end else begin
            hold = rx_hold;
            if (o_out_valid && out_ready) begin
                if (expected_payload_q.size() == 0) begin
                    $display("%0t ns: unexpected payload request, expected none, actual %0h",
                             $time, out_item);
                    err_cnt++;
                end else begin
                    want = expected_payload_q.pop_front();
                    check_field("payload_byte", 16'(want.payload_byte),
                                16'(out_item.payload_byte));
                    check_field("packet_pid", 16'(want.packet_pid), 16'(out_item.packet_pid));
                    check_field("unit_start", 16'(want.unit_start), 16'(out_item.unit_start));
                    check_field("first_of_packet", 16'(want.first_of_packet),
                                16'(out_item.first_of_packet));
                    check_field("last_of_packet", 16'(want.last_of_packet),
                                16'(out_item.last_of_packet));
                end
                hold = draw_gap(rx_burst);
                if ($urandom_range(0, 49) == 0)
                    rx_burst <= !rx_burst;
            end
            if (hold > 0) begin
                out_ready <= 1'b0;
                rx_hold   <= hold - 1;
            end else begin
                out_ready <= 1'b1;
                rx_hold   <= 0;
            end
        end
    end

    // watchdog on cycles with no request moving on either side
    always @(posedge i_clk) begin : watchdog
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
            if (idle_count >= WATCHDOG_LIMIT) begin
                $display("tb_ts_packet_sync_and_pid_filter NOT OK");
                $finish;
            end
        end
    end

    // hold off until the sender is empty and every payload request has come
    task automatic wait_quiet();
        do
            @(negedge i_clk);
        while (pending_q.size() != 0 || in_valid || expected_payload_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // filter write while the block is idle; the predictor follows at once
    task automatic cfg_write(logic idx, logic [PID_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_PID_A)
            flt_a = val;
        else
            flt_b = val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        // pre-lock noise: byte extremes, stray sync bytes, drains that carry a sync value
        t_in_item warmup [20] = '{
            {CMD_BYTE, 8'h00}, {CMD_BYTE, 8'hFF}, {CMD_BYTE, SYNC_BYTE},
            {CMD_DRAIN, SYNC_BYTE}, {CMD_BYTE, SYNC_BYTE}, {CMD_DRAIN, 8'hFF},
            {CMD_DRAIN, 8'h00}, {CMD_BYTE, SYNC_BYTE}, {CMD_BYTE, 8'hA5},
            {CMD_BYTE, 8'h5A}, {CMD_BYTE, SYNC_BYTE}, {CMD_BYTE, SYNC_BYTE},
            {CMD_BYTE, SYNC_BYTE}, {CMD_BYTE, 8'h01}, {CMD_BYTE, 8'h80},
            {CMD_BYTE, 8'hFE}, {CMD_BYTE, 8'h7F}, {CMD_BYTE, SYNC_BYTE},
            {CMD_DRAIN, 8'h3C}, {CMD_BYTE, SYNC_BYTE}
        };
        logic [BYTE_W-1:0] pkt [PL];
        logic [PID_W-1:0]  sched_a [N_PHASES];
        logic [PID_W-1:0]  sched_b [N_PHASES];
        logic [PID_W-1:0]  pid;
        logic [1:0]        ctrl;
        logic              pusi;
        logic [BYTE_W-1:0] adapt;
        int                ph;

        // filter settings per phase: reset values first, then extremes and random pids
        for (int p = 0; p < 3; p++) begin
            sched_a[p] = PID_A_RESET;
            sched_b[p] = PID_B_RESET;
        end
        sched_a[3] = '1;
        sched_b[3] = PID_W'($urandom);
        sched_a[4] = PID_W'($urandom);
        sched_b[4] = '0;
        sched_a[5] = PID_W'($urandom);
        sched_b[5] = sched_a[5];
        sched_a[6] = PID_W'($urandom);
        sched_b[6] = '1;

        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (warmup[i])
            pending_q.push_back(warmup[i]);

        for (int p = 0; p < N_PHASES; p++) begin
            // sender pauses at each packet boundary until all payload has come back
            if (p > 0)
                wait_quiet();
            if (p >= 3) begin
                cfg_write(CFG_PID_A, sched_a[p]);
                cfg_write(CFG_PID_B, sched_b[p]);
            end
            @(negedge i_clk);
            if (p == N_PHASES - 1) begin
                // flush: push the last two packets out of the delay line
                repeat (LINE_DEPTH)
                    pending_q.push_back({CMD_DRAIN, BYTE_W'($urandom)});
            end else begin
                // packet p leaves the delay line two packets later, so aim at that phase
                ph    = (p + 2 < N_PHASES) ? p + 2 : N_PHASES - 1;
                pusi  = 1'($urandom);
                adapt = BYTE_W'($urandom_range(0, 20));
                if ($urandom_range(0, 7) < 4)
                    pid = sched_a[ph];
                else if ($urandom_range(0, 3) == 0)
                    pid = PID_W'($urandom);
                else
                    pid = sched_b[ph];
                case (p)
                    0: begin
                        // reserved control, payload right after the header
                        ctrl = ADAPT_RESERVED;
                        pusi = 1'b0;
                        pid  = sched_a[ph];
                    end
                    1: begin
                        // offset 187: a single byte that is both first and last
                        ctrl  = ADAPT_AND_PAYLOAD;
                        pusi  = 1'b1;
                        adapt = 8'd181;
                        pid   = sched_b[ph];
                    end
                    2: begin
                        // offset exactly one packet length: nothing emitted
                        ctrl  = ADAPT_ONLY;
                        pusi  = 1'b0;
                        adapt = 8'd183;
                    end
                    default: begin
                        ctrl = 2'($urandom);
                        case ($urandom_range(0, 3))
                            0: adapt = BYTE_W'($urandom_range(178, 184));
                            1: adapt = BYTE_W'($urandom_range(185, 255));
                            default: ;
                        endcase
                    end
                endcase
                for (int k = 0; k < PL; k++)
                    pkt[k] = BYTE_W'($urandom);
                // once locked, a broken sync byte must not matter
                if (p < 4 || $urandom_range(0, 2) != 0)
                    pkt[0] = SYNC_BYTE;
                pkt[1] = {1'($urandom), pusi, 1'($urandom), pid[12:8]};
                pkt[2] = pid[7:0];
                pkt[3] = {2'($urandom), ctrl, 4'($urandom)};
                if (ctrl == ADAPT_ONLY || ctrl == ADAPT_AND_PAYLOAD)
                    pkt[4] = adapt;
                for (int k = 0; k < PL; k++) begin
                    // drains inside packets only after lock, they must not shift the cut
                    if (p >= 3 && k > 0 && $urandom_range(0, 47) == 0)
                        pending_q.push_back({CMD_DRAIN, BYTE_W'($urandom)});
                    pending_q.push_back({CMD_BYTE, pkt[k]});
                end
            end
        end

        wait_quiet();
        if (err_cnt == 0 && expected_payload_q.size() == 0)
            $display("tb_ts_packet_sync_and_pid_filter OK");
        else
            $display("tb_ts_packet_sync_and_pid_filter NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
src/tspf_pkg.sv
src/tspf_ram.sv
src/ts_packet_sync_and_pid_filter.sv
bench/tb_ts_packet_sync_and_pid_filter.sv
